// ----- hw/rtl/least_loaded_chunk_assigner_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the least-loaded chunk assigner
// Every property is sampled on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LEAST_LOADED_CHUNK_ASSIGNER_DEFINES_SVH
`define LEAST_LOADED_CHUNK_ASSIGNER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define LLCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define LLCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/llca_pkg.sv -----
// ----------------------------------------------------------------------------
// llca_pkg
// Beat types, register codes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package llca_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] CHUNK_SIZE_RESET  = 16'd1024;
  localparam logic [3:0]  QUEUE_COUNT_RESET = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHUNK_SIZE  = 2'd0,
    REG_QUEUE_COUNT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] src_degree;
    logic [31:0] dst_degree;
    logic        start_of_list;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  queue_id;
    logic [31:0] slot;
    logic        chunk_start;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // latch the edge, apply the list clear
    logic decide;  // open a chunk if due, prepare the scan
    logic scan;    // advance the least-load scan
    logic rdreq;   // read score and length of the current queue
    logic update;  // write back and load the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic opens;      // next edge opens a chunk
    logic fill;       // chunks still handed out in order
    logic scan_done;  // last score of the scan has been compared
    logic out_busy;   // output register full and held
  } dp_sts_t;

endpackage

// ----- hw/rtl/least_loaded_chunk_assigner.sv -----
// Sequence: an accepted edge goes through decide, read and write back to its
// result beat, with a least-load scan over the queues in use after decide
// when a chunk opens by least load. A new edge is taken only once the last
// one is written back; the scan reads one score a cycle from the score RAM.
// Reset: all scores, lengths and counters read as zero, no clearing pass.
// ----------------------------------------------------------------------------
// least_loaded_chunk_assigner
// Cuts an edge stream into chunks and assigns each chunk to a queue: the
// first chunks go to queues in order, later ones to the least-loaded queue.
// ----------------------------------------------------------------------------
module least_loaded_chunk_assigner #(
  parameter int unsigned MAX_QUEUES  = 8,
  parameter int unsigned SCORE_WIDTH = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // edge beats in
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  llca_pkg::in_item_t                  in_data_i,
  // result beats out
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output llca_pkg::out_item_t                 out_data_o,
  // register writes
  input  logic                                cfg_we_i,
  input  logic [llca_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [llca_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import llca_pkg::*;

  logic [15:0] chunk_size_q;
  logic [3:0]  queue_count_q;
  dp_cmd_t     cmd;
  dp_sts_t     sts;

  // Register file: the user must make writes land only while the block is idle;
  // the block does not enforce it, and the datapath reads these directly. Unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_size_q  <= CHUNK_SIZE_RESET;
      queue_count_q <= QUEUE_COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CHUNK_SIZE: begin
          chunk_size_q <= cfg_data_i[15:0];
        end
        REG_QUEUE_COUNT: begin
          queue_count_q <= cfg_data_i[3:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Controller: one edge at a time through decide, optional scan, read, write back.
  llca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: score and length RAMs with valid bits, chunk counters and
  // the output register that lets the next edge in while a beat waits.
  llca_datapath #(
    .MAX_QUEUES  (MAX_QUEUES),
    .SCORE_WIDTH (SCORE_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_data_i     (in_data_i),
    .chunk_size_i  (chunk_size_q),
    .queue_count_i (queue_count_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule

// ----- hw/rtl/llca_ram.sv -----
// ----------------------------------------------------------------------------
// llca_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module llca_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/llca_ctrl.sv -----
// ----------------------------------------------------------------------------
// llca_ctrl
// Sequencer for one edge: decide, optional least-load scan, read, write back.
// ----------------------------------------------------------------------------
module llca_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  llca_pkg::dp_sts_t sts_i,
  output llca_pkg::dp_cmd_t cmd_o
);
  import llca_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECIDE = 5'b00010,
    S_SCAN   = 5'b00100,
    S_RDREQ  = 5'b01000,
    S_UPDATE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = (sts_i.opens && !sts_i.fill) ? S_SCAN : S_RDREQ;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_RDREQ;
        end
      end
      S_RDREQ: begin
        cmd_o.rdreq = 1'b1;
        state_d     = S_UPDATE;
      end
      S_UPDATE: begin
        // hold until the output register can take the result
        if (!sts_i.out_busy) begin
          cmd_o.update = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ----- hw/rtl/llca_datapath.sv -----
// ----------------------------------------------------------------------------
// llca_datapath
// Queue scores and lengths, chunk bookkeeping, least-load scan, output beat.
// ----------------------------------------------------------------------------
`include "least_loaded_chunk_assigner_defines.svh"

module llca_datapath #(
  parameter int unsigned MAX_QUEUES  = 8,
  parameter int unsigned SCORE_WIDTH = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  llca_pkg::dp_cmd_t   cmd_i,
  output llca_pkg::dp_sts_t   sts_o,
  input  llca_pkg::in_item_t  in_data_i,
  input  logic [15:0]         chunk_size_i,
  input  logic [3:0]          queue_count_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output llca_pkg::out_item_t out_data_o
);
  import llca_pkg::*;

  localparam int unsigned QW = $clog2(MAX_QUEUES);
  localparam int unsigned CW = $clog2(MAX_QUEUES + 1);

  logic [31:0]             add_q;
  logic [15:0]             offset_q;
  logic [CW-1:0]           chunks_q;
  logic [QW-1:0]           cur_q;
  logic                    opens_q;
  logic [MAX_QUEUES-1:0]   ent_vld_q;
  logic [CW-1:0]           rd_idx_q;
  logic                    scan_vld_q;
  logic [QW-1:0]           scan_tag_q;
  logic [QW-1:0]           best_idx_q;
  logic [SCORE_WIDTH-1:0]  best_score_q;
  logic                    rd_vld_q;
  logic                    out_valid_q;
  out_item_t               out_q;

  logic [CW-1:0]           count_eff;
  logic [15:0]             size_eff;
  logic                    scan_issue;
  logic                    score_re;
  logic [QW-1:0]           score_raddr;
  logic [SCORE_WIDTH-1:0]  score_rdata;
  logic [31:0]             len_rdata;
  logic [SCORE_WIDTH-1:0]  score_cur;
  logic [31:0]             len_cur;
  logic                    take;
  logic [QW-1:0]           best_idx_d;
  logic [SCORE_WIDTH-1:0]  best_score_d;
  logic [SCORE_WIDTH:0]    score_sum;
  logic [SCORE_WIDTH-1:0]  score_new;
  logic [16:0]             offset_inc;

  // Queue count clamped to 1..MAX_QUEUES, chunk size zero acts as one.
  always_comb begin
    if (queue_count_i == 4'd0) begin
      count_eff = CW'(1);
    end else if (32'(queue_count_i) > MAX_QUEUES) begin
      count_eff = CW'(MAX_QUEUES);
    end else begin
      count_eff = CW'(queue_count_i);
    end
  end

  assign size_eff = (chunk_size_i == 16'd0) ? 16'd1 : chunk_size_i;

  assign scan_issue  = cmd_i.scan && (rd_idx_q < count_eff);
  assign score_re    = scan_issue || cmd_i.rdreq;
  assign score_raddr = cmd_i.scan ? rd_idx_q[QW-1:0] : cur_q;

  // Entries never written since the last clear read as zero.
  assign score_cur = rd_vld_q ? score_rdata : '0;
  assign len_cur   = rd_vld_q ? len_rdata : 32'd0;

  assign take         = (scan_tag_q == '0) || (score_cur < best_score_q);
  assign best_idx_d   = take ? scan_tag_q : best_idx_q;
  assign best_score_d = take ? score_cur : best_score_q;

  assign score_sum = {1'b0, score_cur} + (SCORE_WIDTH + 1)'(add_q);
  assign score_new = score_sum[SCORE_WIDTH] ? '1 : score_sum[SCORE_WIDTH-1:0];

  assign offset_inc = {1'b0, offset_q} + 17'd1;

  llca_ram #(
    .WIDTH (SCORE_WIDTH),
    .DEPTH (MAX_QUEUES)
  ) u_score_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (cur_q),
    .wdata_i (score_new),
    .re_i    (score_re),
    .raddr_i (score_raddr),
    .rdata_o (score_rdata)
  );

  llca_ram #(
    .WIDTH (32),
    .DEPTH (MAX_QUEUES)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (cur_q),
    .wdata_i (len_cur + 32'd1),
    .re_i    (cmd_i.rdreq),
    .raddr_i (cur_q),
    .rdata_o (len_rdata)
  );

  // Bookkeeping state, cleared by reset and, all but the output valid bit, by a start-of-list beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      chunks_q    <= '0;
      cur_q       <= '0;
      ent_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept && in_data_i.start_of_list) begin
        offset_q  <= '0;
        chunks_q  <= '0;
        cur_q     <= '0;
        ent_vld_q <= '0;
      end
      if (cmd_i.decide && (offset_q == 16'd0) && (chunks_q < count_eff)) begin
        cur_q    <= chunks_q[QW-1:0];
        chunks_q <= chunks_q + CW'(1);
      end
      if (cmd_i.scan && sts_o.scan_done) begin
        cur_q <= best_idx_d;
      end
      if (cmd_i.update) begin
        ent_vld_q[cur_q] <= 1'b1;
        offset_q <= (offset_inc >= {1'b0, size_eff}) ? 16'd0 : offset_inc[15:0];
      end
      if (cmd_i.update) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and scan registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      add_q <= (in_data_i.src_degree < in_data_i.dst_degree) ?
               in_data_i.src_degree : in_data_i.dst_degree;
    end
    if (cmd_i.decide) begin
      opens_q    <= (offset_q == 16'd0);
      rd_idx_q   <= '0;
      scan_vld_q <= 1'b0;
    end
    if (cmd_i.scan) begin
      scan_vld_q <= scan_issue;
      scan_tag_q <= rd_idx_q[QW-1:0];
      if (scan_issue) begin
        rd_idx_q <= rd_idx_q + CW'(1);
      end
      if (scan_vld_q) begin
        best_idx_q   <= best_idx_d;
        best_score_q <= best_score_d;
      end
    end
    if (score_re) begin
      rd_vld_q <= ent_vld_q[score_raddr];
    end
    if (cmd_i.update) begin
      out_q.queue_id    <= 3'(cur_q);
      out_q.slot        <= len_cur;
      out_q.chunk_start <= opens_q;
    end
  end

  assign sts_o.opens     = (offset_q == 16'd0);
  assign sts_o.fill      = (chunks_q < count_eff);
  assign sts_o.scan_done = scan_vld_q && (CW'(scan_tag_q) == (count_eff - CW'(1)));
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LLCA_ASSERT(a_no_overwrite, cmd_i.update |-> !(out_valid_q && out_stall_i), "held beat overwritten")
  `LLCA_ASSERT(a_out_from_update, $rose(out_valid_q) |-> $past(cmd_i.update), "beat without update")
  `LLCA_ASSERT(a_best_in_range, (cmd_i.scan && sts_o.scan_done) |-> (CW'(best_idx_d) < count_eff), "least-load pick out of range")

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for least_loaded_chunk_assigner
// Streams edge beats through the assigner and checks every result beat
// against an in-bench partitioning predictor. The test tasks cover register
// defaults and the out-of-range settings. A long receiver hold-off builds
// backpressure, a run of all-maximum degrees loads one queue heavily before
// a second queue competes, and random phases run with their own register
// settings, most of them with sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import llca_pkg::*;

  localparam int unsigned MAXQ        = 8;
  localparam int unsigned SCORE_W     = 48;
  // Pad well past the worst edge latency before a register write.
  localparam int unsigned SETTLE_CYC  = 24;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;
  logic        cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  least_loaded_chunk_assigner #(
    .MAX_QUEUES (MAXQ),
    .SCORE_WIDTH(SCORE_W)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Predictor state: the bench's own copy of the registers and the queues
  // --------------------------------------------------------------------------
  logic [15:0]        chunk_size_q;
  logic [3:0]         queue_count_q;
  logic [SCORE_W-1:0] load_score [MAXQ];
  logic [31:0]        fill_level [MAXQ];
  logic [2:0]         open_queue;
  int unsigned        chunk_pos;      // wide on purpose: survives a shrinking chunk size
  int unsigned        chunks_opened;

  out_item_t   results_due[$];        // predicted result beats, oldest first
  out_item_t   want_beat;
  int unsigned errors;

  // Traffic shaping knobs shared by the test tasks and the receiver.
  bit          traffic_idles;
  int unsigned hold_off_req;
  int unsigned burst_left;

  function automatic void clear_partition_state();
    for (int i = 0; i < MAXQ; i++) begin
      load_score[i] = '0;
      fill_level[i] = '0;
    end
    open_queue    = '0;
    chunk_pos     = 0;
    chunks_opened = 0;
  endfunction

  // Assign one edge: pick its queue, report its slot, then charge the queue.
  function automatic out_item_t predict_assignment(input in_item_t e);
    int unsigned       n_use;
    int unsigned       eff_size;
    logic [31:0]       charge;
    logic [SCORE_W:0]  sum;
    out_item_t         r;
    n_use    = (queue_count_q == 0) ? 1 :
               (queue_count_q > MAXQ) ? MAXQ : int'(queue_count_q);
    eff_size = (chunk_size_q == 0) ? 1 : int'(chunk_size_q);
    if (e.start_of_list) clear_partition_state();
    r.chunk_start = 1'b0;
    if (chunk_pos == 0) begin
      r.chunk_start = 1'b1;
      if (chunks_opened < n_use) begin
        // still handing chunks out in queue order
        open_queue = chunks_opened[2:0];
        chunks_opened++;
      end else begin
        // least load among queues in use; a tie keeps the lower index
        open_queue = '0;
        for (int i = 1; i < n_use; i++) begin
          if (load_score[i] < load_score[open_queue]) open_queue = i[2:0];
        end
      end
    end
    r.queue_id = open_queue;
    r.slot     = fill_level[open_queue];
    fill_level[open_queue] = fill_level[open_queue] + 32'd1;
    charge = (e.src_degree < e.dst_degree) ? e.src_degree : e.dst_degree;
    sum    = {1'b0, load_score[open_queue]} + {{(SCORE_W-32+1){1'b0}}, charge};
    load_score[open_queue] = sum[SCORE_W] ? {SCORE_W{1'b1}} : sum[SCORE_W-1:0];
    chunk_pos++;
    if (chunk_pos >= eff_size) chunk_pos = 0;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Receiver: stall on a pattern of its own, or hold off on request
  // --------------------------------------------------------------------------
  initial begin : rx_stall_gen
    int unsigned hold_left;
    int unsigned phase_left;
    int unsigned stall_pct;
    hold_left   = 0;
    phase_left  = 0;
    stall_pct   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req != 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left != 0) begin
        // hold off for the whole requested stretch, counted here
        out_stall_i = 1'b1;
        hold_left--;
      end else if (!traffic_idles) begin
        out_stall_i = 1'b0;
      end else begin
        // pick a new stall density for each random-length phase, including none at all
        if (phase_left == 0) begin
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            2:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
          phase_left = $urandom_range(8, 60);
        end
        phase_left--;
        out_stall_i = ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each accepted result beat with the oldest
  // prediction, field by field
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (results_due.size() == 0) begin
        $display("%0t: result beat with nothing expected: queue %0d slot %0d start %0b",
                 $time, out_data_o.queue_id, out_data_o.slot, out_data_o.chunk_start);
        errors++;
      end else begin
        want_beat = results_due.pop_front();
        if (out_data_o.queue_id !== want_beat.queue_id) begin
          $display("%0t: queue_id mismatch: expected %0d, got %0d",
                   $time, want_beat.queue_id, out_data_o.queue_id);
          errors++;
        end
        if (out_data_o.slot !== want_beat.slot) begin
          $display("%0t: slot mismatch: expected %0d, got %0d",
                   $time, want_beat.slot, out_data_o.slot);
          errors++;
        end
        if (out_data_o.chunk_start !== want_beat.chunk_start) begin
          $display("%0t: chunk_start mismatch: expected %0b, got %0b",
                   $time, want_beat.chunk_start, out_data_o.chunk_start);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run at a generous cycle limit
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offer one edge beat from a falling edge; hold it until accepted, then
  // record its prediction and return on the next falling edge.
  task automatic send_edge(input in_item_t e);
    in_valid_i = 1'b1;
    in_data_i  = e;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    results_due.insert(results_due.size(), predict_assignment(e));
    @(negedge clk_i);
  endtask

  function automatic in_item_t make_edge(input logic [31:0] src, input logic [31:0] dst,
                                         input logic first);
    in_item_t e;
    e.src_degree    = src;
    e.dst_degree    = dst;
    e.start_of_list = first;
    return e;
  endfunction

  function automatic logic [31:0] rand_degree();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2, 3, 4: return $urandom_range(0, 64);
      5, 6:    return $urandom_range(0, 100000);
      default: return $urandom;
    endcase
  endfunction

  // Drop valid and wait until every predicted beat has arrived.
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (results_due.size() != 0) @(negedge clk_i);
  endtask

  // Write a register only with the block idle.
  task automatic reg_write(input cfg_reg_e idx, input logic [15:0] val);
    wait_drained();
    repeat (SETTLE_CYC) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_data_i  = 16'($urandom);
    if (idx == REG_CHUNK_SIZE) chunk_size_q = val;
    else                       queue_count_q = val[3:0];
  endtask

  // Between bursts, drop valid for a random gap when idling is on.
  task automatic sender_gap();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (traffic_idles) begin
        gap = $urandom_range(0, 7);
        if (gap != 0) begin
          in_valid_i = 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
    end
    burst_left--;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: chunk size 1024, eight queues; no start flag on the first edge.
  task automatic test_reset_defaults();
    send_edge(make_edge(32'h0, 32'h0, 1'b0));
    send_edge(make_edge(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    send_edge(make_edge(32'hFFFF_FFFF, 32'h0, 1'b0));
    send_edge(make_edge(32'h1, 32'hFFFF_FFFE, 1'b0));
    send_edge(make_edge(32'hAAAA_AAAA, 32'h5555_5555, 1'b0));
  endtask

  // Zero chunk size, queue count zero and above range, ties, mid-list changes.
  task automatic test_register_corners();
    reg_write(REG_CHUNK_SIZE, 16'h0);
    reg_write(REG_QUEUE_COUNT, 16'h5A50);       // low nibble 0 acts as one queue
    send_edge(make_edge(32'd7, 32'd9, 1'b1));
    send_edge(make_edge(32'd3, 32'd2, 1'b0));
    send_edge(make_edge(32'd0, 32'd5, 1'b0));
    reg_write(REG_QUEUE_COUNT, 16'hA5AF);       // 15 clamps to eight queues
    reg_write(REG_CHUNK_SIZE, 16'd2);
    // zero degrees keep all scores tied: the least-load pick falls to queue 0
    for (int i = 0; i < 20; i++)
      send_edge(make_edge(32'h0, (i < 16) ? 32'h0 : 32'd100, i == 0));
    // change both registers mid-list, no start flag
    reg_write(REG_QUEUE_COUNT, 16'd3);
    reg_write(REG_CHUNK_SIZE, 16'd3);
    for (int i = 0; i < 6; i++) send_edge(make_edge(rand_degree(), rand_degree(), 1'b0));
  endtask

  // Long receiver hold-off while the sender keeps offering: the block fills.
  task automatic test_backpressure();
    reg_write(REG_CHUNK_SIZE, 16'd3);
    reg_write(REG_QUEUE_COUNT, 16'd4);
    hold_off_req = 300;
    for (int i = 0; i < 40; i++) send_edge(make_edge(rand_degree(), rand_degree(), i == 0));
    // pause until every predicted beat is back
    wait_drained();
    for (int i = 0; i < 10; i++) send_edge(make_edge(rand_degree(), rand_degree(), 1'b0));
  endtask

  // Load queue 0 with maximum degrees, then let queue 1 compete.
  task automatic test_max_degrees();
    traffic_idles = 1'b0;
    reg_write(REG_QUEUE_COUNT, 16'd1);
    reg_write(REG_CHUNK_SIZE, 16'd16);
    for (int i = 0; i < 48; i++)
      send_edge(make_edge(32'hFFFF_FFFF, 32'hFFFF_FFFF, i == 0));
    reg_write(REG_QUEUE_COUNT, 16'd2);
    reg_write(REG_CHUNK_SIZE, 16'd1);
    for (int i = 0; i < 8; i++) send_edge(make_edge(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    traffic_idles = 1'b1;
  endtask

  // Random phases, each with its own registers and idling.
  task automatic test_random_traffic();
    int unsigned n_items;
    logic [15:0] size_pick;
    for (int phase = 0; phase < 8; phase++) begin
      traffic_idles = (phase % 3 != 2);
      if ($urandom_range(0, 7) == 0) size_pick = 16'($urandom_range(0, 16'hFFFF));
      else                           size_pick = 16'($urandom_range(0, 12));
      reg_write(REG_CHUNK_SIZE, size_pick);
      reg_write(REG_QUEUE_COUNT, 16'($urandom_range(0, 16'hFFFF)));
      n_items = (size_pick > 64) ? 35 : 85;
      burst_left = 0;
      for (int i = 0; i < n_items; i++) begin
        sender_gap();
        if (phase == 4 && i == n_items / 2) wait_drained();
        send_edge(make_edge(rand_degree(), rand_degree(),
                            (i == 0) ? 1'($urandom_range(0, 1)) :
                                       ($urandom_range(0, 99) < 3)));
      end
    end
    traffic_idles = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_CHUNK_SIZE;
    cfg_data_i    = '0;
    errors        = 0;
    traffic_idles = 1'b1;
    hold_off_req  = 0;
    burst_left    = 0;
    chunk_size_q  = CHUNK_SIZE_RESET;
    queue_count_q = QUEUE_COUNT_RESET;
    clear_partition_state();

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_register_corners();
    test_backpressure();
    test_max_degrees();
    test_random_traffic();

    wait_drained();
    repeat (SETTLE_CYC) @(negedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/llca_pkg.sv
hw/rtl/llca_ram.sv
hw/rtl/llca_ctrl.sv
hw/rtl/llca_datapath.sv
hw/rtl/least_loaded_chunk_assigner.sv
sim/tb_top.sv
